[rtl/wps_pkg.sv]
// Shared types, constants and tables for the waypoint heading steering core.
package wps_pkg;

   localparam int QUEUE_DEPTH_DEF  = 64;
   localparam int CORDIC_STEPS_DEF = 14;

   // Input kinds
   localparam logic [1:0] KIND_LOAD    = 2'd0;
   localparam logic [1:0] KIND_POSE    = 2'd1;
   localparam logic [1:0] KIND_COLLECT = 2'd2;

   // Configuration register indexes
   localparam logic [2:0] REG_DEAD_BAND  = 3'd0;
   localparam logic [2:0] REG_MIN_TURN   = 3'd1;
   localparam logic [2:0] REG_STEER_GAIN = 3'd2;
   localparam logic [2:0] REG_ARRIVE_SQ  = 3'd3;
   localparam logic [2:0] REG_SKIP_COUNT = 3'd4;

   localparam logic [14:0] DEAD_BAND_RST  = 15'd1638;
   localparam logic [14:0] MIN_TURN_RST   = 15'd819;
   localparam logic [15:0] STEER_GAIN_RST = 16'd32768;
   localparam logic [31:0] ARRIVE_SQ_RST  = 32'd41943;
   localparam logic [1:0]  SKIP_COUNT_RST = 2'd2;

   // CORDIC angle constants, Q2.28 radians
   localparam logic signed [31:0] HALF_PI_Q28 = 32'sd421657428;
   // ceil(2^29 / 100): exact floor division by 100 for 22-bit numerators
   localparam logic [22:0] RECIP_100 = 23'd5368710;

   typedef struct packed {
      logic [1:0]         kind;
      logic               path_start;
      logic signed [15:0] coord_x;
      logic signed [15:0] coord_y;
      logic signed [15:0] heading;
   } item_type;

   typedef struct packed {
      logic [14:0] dead_band;
      logic [14:0] min_turn;
      logic [15:0] steer_gain;
      logic [31:0] arrive_dist_sq;
      logic [1:0]  skip_count;
   } cfg_type;

   typedef struct packed {
      logic signed [15:0] steer;
      logic               active;
      logic               arrived;
      logic               collected;
      logic               queue_full;
   } result_type;

   // atan(2^-i) in Q2.28
   function automatic logic signed [31:0] atan_q28(input logic [4:0] idx);
      logic signed [31:0] v;
      case (idx)
         5'd0:  v = 32'sd210828714;
         5'd1:  v = 32'sd124459457;
         5'd2:  v = 32'sd65760959;
         5'd3:  v = 32'sd33381290;
         5'd4:  v = 32'sd16755422;
         5'd5:  v = 32'sd8385879;
         5'd6:  v = 32'sd4193963;
         5'd7:  v = 32'sd2097109;
         5'd8:  v = 32'sd1048571;
         5'd9:  v = 32'sd524287;
         5'd10: v = 32'sd262144;
         5'd11: v = 32'sd131072;
         5'd12: v = 32'sd65536;
         5'd13: v = 32'sd32768;
         5'd14: v = 32'sd16384;
         5'd15: v = 32'sd8192;
         5'd16: v = 32'sd4096;
         5'd17: v = 32'sd2048;
         5'd18: v = 32'sd1024;
         5'd19: v = 32'sd512;
         default: v = 32'sd0;
      endcase
      return v;
   endfunction

endpackage

[rtl/wps_front.sv]
// Front end: accepts request transfers into a two-entry queue for the engine.
module wps_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [47:0]       req_tdata,   // coord_x, coord_y, heading
   input  logic [2:0]        req_tuser,   // kind[1:0], path_start
   output logic              item_valid,
   output wps_pkg::item_type item,
   input  logic              item_pop
);
   import wps_pkg::*;

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   item_type   incoming;
   logic       push, pop;

   // unpack the transfer into item fields
   always_comb begin
      incoming.kind       = req_tuser[1:0];
      incoming.path_start = req_tuser[2];
      incoming.coord_x    = req_tdata[15:0];
      incoming.coord_y    = req_tdata[31:16];
      incoming.heading    = req_tdata[47:32];
   end

   assign req_tready = (cnt_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign item_valid = (cnt_ff != 2'd0);
   assign pop        = item_pop && item_valid;
   assign item       = slot_ff[rd_ptr_ff];

   // advance pointers and count
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // hold queued payload
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= incoming;
      end
   end

endmodule

[rtl/wps_cordic.sv]
// Iterative CORDIC atan2 unit, one rotation step per cycle.
module wps_cordic #(
   parameter int CORDIC_STEPS = wps_pkg::CORDIC_STEPS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [16:0] vec_x,
   input  logic signed [16:0] vec_y,
   output logic               done,
   output logic signed [31:0] angle
);
   import wps_pkg::*;

   localparam int XW = 33;
   localparam int IW = $clog2(CORDIC_STEPS + 1);

   logic signed [XW-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [31:0]   z_ff, z_in;
   logic [IW-1:0]        iter_ff, iter_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic signed [XW-1:0] x0, y0, xs, ys;
   logic signed [31:0]   step_angle;

   assign x0         = XW'(vec_x) <<< 12;
   assign y0         = XW'(vec_y) <<< 12;
   assign xs         = x_ff >>> iter_ff;
   assign ys         = y_ff >>> iter_ff;
   assign step_angle = atan_q28(5'(iter_ff));

   // load with quadrant pre-rotation, then rotate toward y = 0
   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      iter_in = iter_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         iter_in = '0;
         if (vec_x == 17'sd0 && vec_y == 17'sd0) begin
            z_in    = 32'sd0;
            done_in = 1'b1;
         end else begin
            busy_in = 1'b1;
            x_in    = x0;
            y_in    = y0;
            z_in    = 32'sd0;
            if (vec_x < 17'sd0) begin
               if (vec_y >= 17'sd0) begin
                  x_in = y0;
                  y_in = -x0;
                  z_in = HALF_PI_Q28;
               end else begin
                  x_in = -y0;
                  y_in = x0;
                  z_in = -HALF_PI_Q28;
               end
            end
         end
      end else if (busy_ff) begin
         if (y_ff > XW'(0)) begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + step_angle;
         end else begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - step_angle;
         end
         iter_in = iter_ff + 1'b1;
         if (iter_ff == IW'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         iter_ff <= iter_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign done  = done_ff;
   assign angle = z_ff;

endmodule

[rtl/wps_back.sv]
// Back end: waypoint queue, steering arithmetic and the result register.
module wps_back #(
   parameter int QUEUE_DEPTH  = wps_pkg::QUEUE_DEPTH_DEF,
   parameter int CORDIC_STEPS = wps_pkg::CORDIC_STEPS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  wps_pkg::cfg_type    cfg,
   input  logic                item_valid,
   input  wps_pkg::item_type   item,
   output logic                item_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output wps_pkg::result_type rsp
);
   import wps_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_RD   = 4'd1;
   localparam logic [3:0] ST_PRE  = 4'd2;
   localparam logic [3:0] ST_WAIT = 4'd3;
   localparam logic [3:0] ST_ANG  = 4'd4;
   localparam logic [3:0] ST_WRAP = 4'd5;
   localparam logic [3:0] ST_DIV  = 4'd6;
   localparam logic [3:0] ST_ERR  = 4'd7;
   localparam logic [3:0] ST_GAIN = 4'd8;
   localparam logic [3:0] ST_OUT  = 4'd9;

   logic [3:0]          state_ff, state_in;
   item_type            item_ff;
   logic [31:0]         mem [QUEUE_DEPTH];
   logic [31:0]         rd_data_ff;
   logic [PW-1:0]       head_ff, head_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [1:0]          skip_ff, skip_in;
   logic                active_ff, active_in;
   logic                collected_ff, collected_in;
   logic signed [15:0]  steer_ff, steer_in;
   logic                rsp_valid_ff;
   result_type          rsp_ff;

   logic signed [16:0]  dx_ff, dy_ff;
   logic [32:0]         sqx_ff, sqy_ff;
   logic                near_ff;
   logic signed [10:0]  diff_ff;
   logic signed [9:0]   r_ff;
   logic [21:0]         numer_ff;
   logic [44:0]         prod_ff;
   logic [15:0]         emag;
   logic                in_band;
   logic [31:0]         gprod_ff;
   logic signed [15:0]  calc_ff;

   logic                cordic_start, cordic_done;
   logic signed [31:0]  angle;

   logic                commit, mem_we;
   logic [PW-1:0]       slot;
   logic [PW:0]         slot_sum;
   logic [CW-1:0]       count_eff;
   logic [PW-1:0]       head_eff;
   logic [1:0]          skip_eff;
   logic                full;
   logic                arrived;

   wps_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cordic_start),
      .vec_x (dx_ff),
      .vec_y (dy_ff),
      .done  (cordic_done),
      .angle (angle)
   );

   assign item_pop     = (state_ff == ST_IDLE) && item_valid;
   assign cordic_start = (state_ff == ST_PRE);
   assign commit       = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);

   // error magnitude in Q3.13 straight from the reciprocal product
   assign emag    = prod_ff[44:29];
   assign in_band = emag < {1'b0, cfg.dead_band};

   // sequence one item through the engine
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               if (item.kind == KIND_POSE && count_ff != '0) begin
                  state_in = ST_RD;
               end else begin
                  state_in = ST_OUT;
               end
            end
         end
         ST_RD:   state_in = ST_PRE;
         ST_PRE:  state_in = ST_WAIT;
         ST_WAIT: state_in = cordic_done ? ST_ANG : ST_WAIT;
         ST_ANG:  state_in = ST_WRAP;
         ST_WRAP: state_in = ST_DIV;
         ST_DIV:  state_in = ST_ERR;
         ST_ERR:  state_in = in_band ? ST_OUT : ST_GAIN;
         ST_GAIN: state_in = ST_OUT;
         ST_OUT:  state_in = commit ? ST_IDLE : ST_OUT;
         default: state_in = ST_IDLE;
      endcase
   end

   // hold the item under work and read the head waypoint
   always_ff @(posedge clock) begin
      if (item_pop) begin
         item_ff <= item;
      end
      rd_data_ff <= mem[head_ff];
      if (mem_we) begin
         mem[slot] <= {item_ff.coord_x, item_ff.coord_y};
      end
   end

   // steering arithmetic datapath
   logic signed [35:0] zt, zmag, zq;
   logic signed [19:0] ht, hmag, hq;
   logic signed [7:0]  goal_t, cur_t;
   logic signed [10:0] v0, v1;
   logic [15:0]        gmag;

   always_comb begin
      zt     = 36'(angle) * 36'sd10;
      zmag   = (zt < 36'sd0) ? -zt : zt;
      zq     = (zmag + 36'sd134217728) >>> 28;
      goal_t = (zt < 36'sd0) ? -8'(zq) : 8'(zq);
      ht     = 20'(item_ff.heading) * 20'sd10;
      hmag   = (ht < 20'sd0) ? -ht : ht;
      hq     = (hmag + 20'sd4096) >>> 13;
      cur_t  = (ht < 20'sd0) ? -8'(hq) : 8'(hq);
      // remainder by 628 toward zero, then wrap into [-314, 314)
      v0 = diff_ff;
      if (v0 >= 11'sd628) v0 = v0 - 11'sd628;
      if (v0 <= -11'sd628) v0 = v0 + 11'sd628;
      v1 = v0;
      if (v1 < -11'sd314) v1 = v1 + 11'sd628;
      if (v1 >= 11'sd314) v1 = v1 - 11'sd628;
      gmag = 16'((gprod_ff + 32'd32768) >> 16);
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_RD: begin
            dx_ff <= 17'($signed(rd_data_ff[31:16])) - 17'(item_ff.coord_x);
            dy_ff <= 17'($signed(rd_data_ff[15:0])) - 17'(item_ff.coord_y);
         end
         ST_PRE: begin
            sqx_ff <= 33'(34'(dx_ff) * 34'(dx_ff));
            sqy_ff <= 33'(34'(dy_ff) * 34'(dy_ff));
         end
         ST_ANG: begin
            near_ff <= ({1'b0, sqx_ff} + {1'b0, sqy_ff}) < {2'b00, cfg.arrive_dist_sq};
            diff_ff <= 11'(11'(goal_t) - 11'(cur_t)) * 11'sd10;
         end
         ST_WRAP: begin
            r_ff     <= 10'(v1);
            numer_ff <= {(v1 < 11'sd0) ? 12'(-v1) : 12'(v1), 10'd0} * 22'd8 + 22'd50;
         end
         ST_DIV: begin
            prod_ff  <= 45'(numer_ff) * 45'(RECIP_100);
         end
         ST_GAIN: begin
            calc_ff  <= (r_ff > 10'sd0) ? -$signed(gmag) : $signed(gmag);
         end
         default: begin
         end
      endcase
   end

   // second stage of error handling: dead band or gain product
   logic in_band_ff;
   always_ff @(posedge clock) begin
      if (state_ff == ST_ERR) begin
         gprod_ff   <= 32'(32'(cfg.steer_gain) * 32'(emag));
         in_band_ff <= in_band;
      end
   end

   // apply the item to the queue state
   always_comb begin
      head_in      = head_ff;
      count_in     = count_ff;
      skip_in      = skip_ff;
      active_in    = active_ff;
      collected_in = collected_ff;
      steer_in     = steer_ff;
      full         = 1'b0;
      arrived      = 1'b0;
      mem_we       = 1'b0;
      head_eff     = item_ff.path_start ? '0 : head_ff;
      count_eff    = item_ff.path_start ? '0 : count_ff;
      skip_eff     = item_ff.path_start ? cfg.skip_count : skip_ff;
      slot_sum     = {1'b0, head_eff} + (PW + 1)'(count_eff);
      slot         = (slot_sum >= (PW + 1)'(QUEUE_DEPTH)) ?
                     PW'(slot_sum - (PW + 1)'(QUEUE_DEPTH)) : PW'(slot_sum);
      if (commit) begin
         case (item_ff.kind)
            KIND_LOAD: begin
               if (!active_ff) begin
                  head_in  = head_eff;
                  count_in = count_eff;
                  skip_in  = skip_eff;
                  if (skip_eff != 2'd0) begin
                     skip_in = skip_eff - 2'd1;
                  end else if (count_eff >= CW'(QUEUE_DEPTH)) begin
                     full = 1'b1;
                  end else begin
                     mem_we   = 1'b1;
                     count_in = count_eff + 1'b1;
                  end
               end
            end
            KIND_POSE: begin
               if (count_ff != '0) begin
                  steer_in = in_band_ff ?
                             ((r_ff < 10'sd0) ? 16'(cfg.min_turn) : -16'(cfg.min_turn)) :
                             calc_ff;
                  if (near_ff) begin
                     head_in      = (head_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
                     count_in     = count_ff - 1'b1;
                     collected_in = 1'b0;
                     arrived      = 1'b1;
                  end
               end
               active_in = (count_in != '0);
            end
            KIND_COLLECT: collected_in = 1'b1;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         skip_ff      <= 2'd0;
         active_ff    <= 1'b0;
         collected_ff <= 1'b0;
         steer_ff     <= 16'sd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         skip_ff      <= skip_in;
         active_ff    <= active_in;
         collected_ff <= collected_in;
         steer_ff     <= steer_in;
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // load the result register on commit
   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_ff.steer      <= steer_in;
         rsp_ff.active     <= active_in;
         rsp_ff.arrived    <= arrived;
         rsp_ff.collected  <= collected_in;
         rsp_ff.queue_full <= full;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

[rtl/waypoint_heading_steering_core.sv]
// Top level of the waypoint heading steering core.
// Steers toward a queue of waypoints held in an internal memory.
// req channel: one item per transfer; tuser selects the kind (waypoint load,
//   pose step, collected mark) and flags a path start, tdata carries the
//   position (Q8.8) and heading (Q3.13).
// rsp channel: exactly one result per item, in order: the steering command
//   in tdata and the status flags in tuser.
// csr channel: register writes by index, always ready; write only while idle.
// Items are handled one at a time. A load, a mark or a pose with an empty
//   queue goes straight to the result stage; a pose with a waypoint passes
//   through the iterative atan2 unit, which does one rotation per cycle, and
//   the error stages, skipping the gain stage inside the dead band.
// A two-entry request queue and the result register let either side stall:
//   while rsp_tready is low the finished result is held and the engine waits
//   with its next result, the request queue still filling.
// Reset empties the waypoint queue, clears all flags and the held steering
//   command, and loads the register defaults; no clearing pass is needed.
module waypoint_heading_steering_core #(
   parameter int QUEUE_DEPTH  = wps_pkg::QUEUE_DEPTH_DEF,
   parameter int CORDIC_STEPS = wps_pkg::CORDIC_STEPS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // coord_x[15:0], coord_y[31:16], heading[47:32]
   input  logic [2:0]  req_tuser,   // kind[1:0], path_start[2]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // steer[15:0]
   output logic [3:0]  rsp_tuser,   // active, arrived, collected, queue_full
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);
   import wps_pkg::*;

   cfg_type    cfg_ff;
   item_type   item;
   logic       item_valid, item_pop;
   result_type rsp;

   // hold configuration registers
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dead_band      <= DEAD_BAND_RST;
         cfg_ff.min_turn       <= MIN_TURN_RST;
         cfg_ff.steer_gain     <= STEER_GAIN_RST;
         cfg_ff.arrive_dist_sq <= ARRIVE_SQ_RST;
         cfg_ff.skip_count     <= SKIP_COUNT_RST;
      end else if (csr_valid) begin
         case (csr_index)
            REG_DEAD_BAND:  cfg_ff.dead_band      <= csr_data[14:0];
            REG_MIN_TURN:   cfg_ff.min_turn       <= csr_data[14:0];
            REG_STEER_GAIN: cfg_ff.steer_gain     <= csr_data[15:0];
            REG_ARRIVE_SQ:  cfg_ff.arrive_dist_sq <= csr_data;
            REG_SKIP_COUNT: cfg_ff.skip_count     <= csr_data[1:0];
            default: begin
            end
         endcase
      end
   end

   wps_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop)
   );

   wps_back #(
      .QUEUE_DEPTH  (QUEUE_DEPTH),
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp        (rsp)
   );

   assign rsp_tdata = rsp.steer;
   assign rsp_tuser = {rsp.queue_full, rsp.collected, rsp.arrived, rsp.active};

endmodule

[dv/steering_checker.sv]
// Scoreboard for the waypoint heading steering core: predicts and checks every result.
module steering_checker
   import wps_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,
   input  logic [2:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,
   input  logic [3:0]  rsp_tuser,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data,
   output int          fail_count,
   output int          pending
);

   localparam int WP_DEPTH = QUEUE_DEPTH_DEF;
   localparam int ROT_STEPS = CORDIC_STEPS_DEF;
   localparam longint QUARTER_TURN = 64'sd421657428;
   localparam longint UNIT_Q28 = 64'sd268435456;
   localparam longint ROT_ANGLE [0:13] = '{
      210828714, 124459457, 65760959, 33381290, 16755422, 8385879, 4193963,
      2097109, 1048571, 524287, 262144, 131072, 65536, 32768};

   cfg_type            regs;
   logic [31:0]        wp_mem [WP_DEPTH];
   int                 wp_head;
   int                 wp_count;
   int                 skips_left;
   logic               moving;
   logic               got_flag;
   logic signed [15:0] held_steer;
   result_type         steer_q [$];

   initial fail_count = 0;
   initial pending = 0;

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d, expected %0d", what, got, want);
      fail_count++;
   endtask

   // round to nearest, ties away from zero
   function automatic longint round_div(input longint num, input longint den);
      longint mag;
      mag = (num < 0) ? -num : num;
      mag = (mag + den / 2) / den;
      return (num < 0) ? -mag : mag;
   endfunction

   // atan2 in Q2.28 radians by vector rotation
   function automatic longint bearing(input longint y_in, input longint x_in);
      longint x, y, z, t, xs, ys;
      z = 0;
      if (x_in == 0 && y_in == 0) return 0;
      x = x_in * 4096;
      y = y_in * 4096;
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t; z = QUARTER_TURN;
         end else begin
            t = x; x = -y; y = t; z = -QUARTER_TURN;
         end
      end
      for (int i = 0; i < ROT_STEPS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x += ys; y -= xs; z += ROT_ANGLE[i];
         end else begin
            x -= ys; y += xs; z -= ROT_ANGLE[i];
         end
      end
      return z;
   endfunction

   function automatic longint steer_cmd(input longint dx, input longint dy, input longint hd);
      longint cur, goal, e, mag;
      int r;
      cur  = round_div(hd * 10, 8192);
      goal = round_div(bearing(dy, dx) * 10, UNIT_Q28);
      r = int'(10 * (goal - cur)) % 628;
      if (r < -314) r += 628;
      if (r >= 314) r -= 628;
      e = round_div(longint'(r) * 8192, 100);
      mag = (e < 0) ? -e : e;
      // dead band: fixed turn against the error, zero error turns negative
      if (mag < longint'(regs.dead_band))
         return (r < 0) ? longint'(regs.min_turn) : -longint'(regs.min_turn);
      mag = (longint'(regs.steer_gain) * mag + 32768) >>> 16;
      return (e > 0) ? -mag : mag;
   endfunction

   task automatic predict(input logic [2:0] user, input logic [47:0] data);
      result_type r;
      logic [1:0] kind;
      longint cx, cy, hd, dx, dy, d2;
      logic [31:0] w;
      kind = user[1:0];
      cx = longint'($signed(data[15:0]));
      cy = longint'($signed(data[31:16]));
      hd = longint'($signed(data[47:32]));
      r = '0;
      case (kind)
         KIND_LOAD: begin
            if (!moving) begin
               if (user[2]) begin
                  wp_count = 0;
                  wp_head = 0;
                  skips_left = regs.skip_count;
               end
               if (skips_left > 0) skips_left--;
               else if (wp_count >= WP_DEPTH) r.queue_full = 1'b1;
               else begin
                  wp_mem[(wp_head + wp_count) % WP_DEPTH] = {data[15:0], data[31:16]};
                  wp_count++;
               end
            end
         end
         KIND_POSE: begin
            if (wp_count > 0) begin
               w = wp_mem[wp_head];
               dx = longint'($signed(w[31:16])) - cx;
               dy = longint'($signed(w[15:0])) - cy;
               d2 = dx * dx + dy * dy;
               held_steer = 16'(steer_cmd(dx, dy, hd));
               // pop the head waypoint on arrival
               if (d2 < longint'(regs.arrive_dist_sq)) begin
                  wp_head = (wp_head + 1) % WP_DEPTH;
                  wp_count--;
                  got_flag = 1'b0;
                  r.arrived = 1'b1;
               end
            end
            moving = (wp_count != 0);
         end
         KIND_COLLECT: got_flag = 1'b1;
         default: ;
      endcase
      r.steer = held_steer;
      r.active = moving;
      r.collected = got_flag;
      steer_q.push_back(r);
   endtask

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         regs <= '{DEAD_BAND_RST, MIN_TURN_RST, STEER_GAIN_RST, ARRIVE_SQ_RST, SKIP_COUNT_RST};
         wp_head = 0;
         wp_count = 0;
         skips_left = 0;
         moving = 1'b0;
         got_flag = 1'b0;
         held_steer = '0;
         steer_q.delete();
      end else begin
         // register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_DEAD_BAND:  regs.dead_band <= csr_data[14:0];
               REG_MIN_TURN:   regs.min_turn <= csr_data[14:0];
               REG_STEER_GAIN: regs.steer_gain <= csr_data[15:0];
               REG_ARRIVE_SQ:  regs.arrive_dist_sq <= csr_data;
               REG_SKIP_COUNT: regs.skip_count <= csr_data[1:0];
               default: ;
            endcase
         end
         // compare a result transfer with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            if (steer_q.size() == 0) report("unexpected result", rsp_tdata, 0);
            else begin
               want = steer_q.pop_front();
               if (rsp_tdata !== want.steer)
                  report("steer", $signed(rsp_tdata), want.steer);
               if (rsp_tuser[0] !== want.active) report("active", rsp_tuser[0], want.active);
               if (rsp_tuser[1] !== want.arrived) report("arrived", rsp_tuser[1], want.arrived);
               if (rsp_tuser[2] !== want.collected)
                  report("collected", rsp_tuser[2], want.collected);
               if (rsp_tuser[3] !== want.queue_full)
                  report("queue_full", rsp_tuser[3], want.queue_full);
            end
         end
         if (req_tvalid && req_tready) predict(req_tuser, req_tdata);
      end
      pending <= steer_q.size();
   end

endmodule

[dv/tb.sv]
// Testbench top: clock, reset, stimulus and verdict for the waypoint heading steering core.
module tb;
   import wps_pkg::*;

   localparam int ITEM_GOAL = 1950;
   localparam int CYCLE_LIMIT = 2000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic [3:0]  rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_data = '0;
   int          chk_fail;
   int          chk_pending;
   int          sent = 0;
   int          cycles = 0;
   int          skip_now = SKIP_COUNT_RST;
   bit          burst = 1'b0;
   logic signed [15:0] wp_x [$];
   logic signed [15:0] wp_y [$];

   waypoint_heading_steering_core dut (.*);

   steering_checker chk (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .csr_valid, .csr_ready, .csr_index, .csr_data,
      .fail_count(chk_fail), .pending(chk_pending));

   initial begin
      forever #4 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // receiver: one long hold-off first, then random stalls with quiet stretches
   initial begin
      int n;
      @(negedge reset);
      repeat (400) @(posedge clock);
      forever begin
         rsp_tready <= 1'b1;
         n = $urandom_range(0, 99);
         if (n < 8) repeat ($urandom_range(100, 250)) @(posedge clock);
         else @(posedge clock);
         n = $urandom_range(0, 99);
         if (n < 20) begin
            rsp_tready <= 1'b0;
            repeat ((n < 2) ? $urandom_range(20, 60) : $urandom_range(1, 3)) @(posedge clock);
         end
      end
   end

   task automatic send(input logic [1:0] kind, input logic start,
                       input logic [15:0] x, input logic [15:0] y, input logic [15:0] hd);
      int g;
      req_tvalid <= 1'b1;
      req_tuser <= {start, kind};
      req_tdata <= {hd, y, x};
      do @(posedge clock); while (!req_tready);
      sent++;
      if (sent % 50 == 0) burst = $urandom_range(0, 2) == 0;
      g = $urandom_range(0, 99);
      if (!burst && g >= 65) begin
         req_tvalid <= 1'b0;
         repeat ((g >= 97) ? $urandom_range(20, 60) : $urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (chk_pending != 0);
      repeat (30) @(posedge clock);
   endtask

   task automatic set_regs(input logic [14:0] db, input logic [14:0] mt, input logic [15:0] g,
                           input logic [31:0] ad, input logic [1:0] sk);
      wait_idle();
      csr_write(REG_DEAD_BAND, 32'(db));
      csr_write(REG_MIN_TURN, 32'(mt));
      csr_write(REG_STEER_GAIN, 32'(g));
      csr_write(REG_ARRIVE_SQ, ad);
      csr_write(REG_SKIP_COUNT, 32'(sk));
      skip_now = sk;
   endtask

   task automatic noise_item();
      send(2'($urandom_range(0, 3)), 1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
   endtask

   // load a path, then walk the robot onto each waypoint in turn
   task automatic run_path();
      int n, spread, off;
      logic signed [15:0] x, y;
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
      spread = ($urandom_range(0, 4) == 0) ? 32767 : 2000;
      wp_x.delete();
      wp_y.delete();
      for (int i = 0; i < n + skip_now; i++) begin
         x = 16'($signed($urandom_range(0, 2 * spread)) - spread);
         y = 16'($signed($urandom_range(0, 2 * spread)) - spread);
         send(KIND_LOAD, i == 0, x, y, 16'($urandom));
         if (i >= skip_now && wp_x.size() < 64) begin
            wp_x.push_back(x);
            wp_y.push_back(y);
         end
      end
      foreach (wp_x[k]) begin
         repeat ($urandom_range(0, 2)) begin
            send(KIND_POSE, 1'b0, 16'($urandom), 16'($urandom), 16'($urandom));
            if ($urandom_range(0, 9) == 0) noise_item();
         end
         if ($urandom_range(0, 7) == 0) send(KIND_COLLECT, 1'b0, '0, '0, '0);
         off = ($urandom_range(0, 3) == 0) ? 0 : 40;
         send(KIND_POSE, 1'b0,
              16'(wp_x[k] + $signed($urandom_range(0, 2 * off)) - off),
              16'(wp_y[k] + $signed($urandom_range(0, 2 * off)) - off), 16'($urandom));
      end
      send(KIND_POSE, 1'b0, 16'($urandom), 16'($urandom), 16'($urandom));
   endtask

   task automatic random_until(input int goal);
      while (sent < goal) begin
         if ($urandom_range(0, 4) == 0) noise_item();
         else run_path();
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: empty queue, marks, unused kind, skipping, extremes
      send(KIND_POSE, 1'b0, 16'h0000, 16'h0000, 16'h0000);
      send(KIND_COLLECT, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send(2'd3, 1'b1, 16'h8000, 16'h7FFF, 16'h8000);
      send(KIND_LOAD, 1'b1, 16'd256, 16'd0, 16'h0000);
      send(KIND_LOAD, 1'b0, 16'd256, 16'd0, 16'h0000);
      send(KIND_LOAD, 1'b0, 16'd256, 16'd0, 16'h0000);
      send(KIND_LOAD, 1'b0, 16'h8000, 16'h8000, 16'h7FFF);
      send(KIND_LOAD, 1'b0, 16'h7FFF, 16'h7FFF, 16'h8000);
      // zero heading error toward the first waypoint
      send(KIND_POSE, 1'b0, 16'h0000, 16'h0000, 16'h0000);
      send(KIND_POSE, 1'b0, 16'h0000, 16'h0000, 16'h7FFF);
      send(KIND_POSE, 1'b0, 16'h7FFF, 16'h8000, 16'h8000);
      // load while active is ignored
      send(KIND_LOAD, 1'b1, 16'h1234, 16'h4321, 16'h0000);
      // robot exactly on each waypoint
      send(KIND_POSE, 1'b0, 16'd256, 16'd0, 16'h1000);
      send(KIND_COLLECT, 1'b0, 16'h0000, 16'h0000, 16'h0000);
      send(KIND_POSE, 1'b0, 16'h8000, 16'h8000, 16'hE000);
      send(KIND_POSE, 1'b0, 16'h7FFF, 16'h7FFF, 16'hFFFF);
      send(KIND_POSE, 1'b0, 16'h0000, 16'h0000, 16'h0000);
      send(2'd3, 1'b0, 16'h0000, 16'h0000, 16'h0000);

      random_until(600);
      set_regs(15'h7FFF, 15'd0, 16'd0, 32'd0, 2'd3);
      random_until(750);
      set_regs(15'd0, 15'h7FFF, 16'hFFFF, 32'hFFFF_FFFF, 2'd0);
      random_until(1150);
      set_regs(15'($urandom_range(0, 4000)), 15'($urandom), 16'($urandom),
               32'($urandom_range(20000, 300000)), 2'($urandom));
      random_until(1550);
      set_regs(DEAD_BAND_RST, MIN_TURN_RST, 16'($urandom), ARRIVE_SQ_RST, 2'd1);
      random_until(ITEM_GOAL);

      wait_idle();
      if (chk_fail == 0 && chk_pending == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/wps_pkg.sv
rtl/wps_front.sv
rtl/wps_cordic.sv
rtl/wps_back.sv
rtl/waypoint_heading_steering_core.sv
dv/steering_checker.sv
dv/tb.sv
